// File: design/ecpa_pkg.sv
// shared types and constants for the elliptic curve point add and multiply block
// no dependencies; used by the arithmetic unit, the top level and the testbench
`default_nettype none

package ecpa_pkg;

   localparam int DEF_COORD_WIDTH  = 16;
   localparam int DEF_SCALAR_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH  = 1;

   localparam int MODULUS_RESET = 97;
   localparam int CURVE_A_RESET = 2;
   localparam int TRIPLE        = 3;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CURVE_A = 1'd1;

   // command codes
   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_MUL = 1'b1;

   typedef enum logic {
      ALU_MULMOD = 1'b0,
      ALU_DIVIDE = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

   // operand reduction order
   typedef enum logic [2:0] {
      RED_CURVE_A  = 3'd0,
      RED_P_X      = 3'd1,
      RED_P_Y      = 3'd2,
      RED_Q_X      = 3'd3,
      RED_Q_Y      = 3'd4,
      RED_FINISHED = 3'd5
   } red_sel_type;

endpackage

`default_nettype wire

// File: design/ecpa_if.sv
// channel interfaces of the elliptic curve point add and multiply block
// request, response and register write channels; no package dependency
`default_nettype none

interface ecpa_req_if #(
   parameter int COORD_WIDTH  = 16,
   parameter int SCALAR_WIDTH = 16
);
   logic                    valid;
   logic                    ready;
   logic                    command;
   logic [COORD_WIDTH-1:0]  p_x;
   logic [COORD_WIDTH-1:0]  p_y;
   logic                    p_at_infinity;
   logic [COORD_WIDTH-1:0]  q_x;
   logic [COORD_WIDTH-1:0]  q_y;
   logic                    q_at_infinity;
   logic [SCALAR_WIDTH-1:0] scalar;

   modport source (output valid, command, p_x, p_y, p_at_infinity, q_x, q_y,
                   q_at_infinity, scalar, input ready);
   modport sink   (input valid, command, p_x, p_y, p_at_infinity, q_x, q_y,
                   q_at_infinity, scalar, output ready);
endinterface

interface ecpa_rsp_if #(
   parameter int COORD_WIDTH = 16
);
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] r_x;
   logic [COORD_WIDTH-1:0] r_y;
   logic                   r_at_infinity;

   modport source (output valid, r_x, r_y, r_at_infinity, input ready);
   modport sink   (input valid, r_x, r_y, r_at_infinity, output ready);
endinterface

interface ecpa_csr_if #(
   parameter int INDEX_WIDTH = 1,
   parameter int DATA_WIDTH  = 16
);
   logic                   valid;
   logic                   ready;
   logic [INDEX_WIDTH-1:0] index;
   logic [DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/ecpa_alu.sv
// shared bit-serial unit: modular multiply (a*b mod m) or unsigned divide (a / m)
// one bit per cycle; uses ecpa_pkg
`default_nettype none

module ecpa_alu #(
   parameter int COORD_WIDTH = ecpa_pkg::DEF_COORD_WIDTH
) (
   input  wire                        clock,
   input  wire                        reset,
   input  ecpa_pkg::alu_cmd_type      cmd,
   input  wire  [COORD_WIDTH-1:0]     a,
   input  wire  [COORD_WIDTH-1:0]     b,
   input  wire  [COORD_WIDTH-1:0]     m,
   output ecpa_pkg::alu_stat_type     stat,
   output logic [COORD_WIDTH-1:0]     res,
   output logic [COORD_WIDTH-1:0]     quo
);
   import ecpa_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int CNT_WIDTH = (CW > 2) ? $clog2(CW) : 1;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   alu_op_type           op_ff, op_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [CW-1:0]        acc_ff, acc_in;
   logic [CW-1:0]        sh_ff, sh_in;
   logic [CW-1:0]        opa_ff, opa_in;
   logic [CW-1:0]        m_ff, m_in;

   logic [CW:0] dbl, sum, trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      opa_in  = opa_ff;
      m_in    = m_ff;
      dbl     = '0;
      sum     = '0;
      trial   = '0;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = CNT_WIDTH'(CW - 1);
         acc_in  = '0;
         opa_in  = a;
         sh_in   = (cmd.op == ALU_DIVIDE) ? a : b;
         m_in    = m;
      end else if (busy_ff) begin
         unique case (op_ff)
            ALU_MULMOD: begin
               // msb first: acc = 2*acc + bit*a, reduced each step
               dbl = {acc_ff, 1'b0};
               if (dbl >= {1'b0, m_ff}) dbl = dbl - {1'b0, m_ff};
               sum = dbl;
               if (sh_ff[CW-1]) begin
                  sum = dbl + {1'b0, opa_ff};
                  if (sum >= {1'b0, m_ff}) sum = sum - {1'b0, m_ff};
               end
               acc_in = sum[CW-1:0];
               sh_in  = {sh_ff[CW-2:0], 1'b0};
            end
            ALU_DIVIDE: begin
               // restoring division, quotient bits shift into sh
               trial = {acc_ff, sh_ff[CW-1]};
               if (trial >= {1'b0, m_ff}) begin
                  trial = trial - {1'b0, m_ff};
                  sh_in = {sh_ff[CW-2:0], 1'b1};
               end else begin
                  sh_in = {sh_ff[CW-2:0], 1'b0};
               end
               acc_in = trial[CW-1:0];
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      opa_ff <= opa_in;
      m_ff   <= m_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign res       = acc_ff;
   assign quo       = sh_ff;

endmodule

`default_nettype wire

// File: design/ec_point_add_and_multiply.sv
// top level of the elliptic curve point add and multiply block
// uses ecpa_pkg, the channel interfaces in ecpa_if.sv and the ecpa_alu unit
`default_nettype none

// Affine point arithmetic on y^2 = x^3 + a*x + b over the integers modulo a
// configured modulus. Command 0 adds P and Q (chord or tangent rule, with
// infinity handling); command 1 multiplies P by a scalar by repeated addition
// R = R + P, and a scalar of zero gives infinity. One transaction at a time:
// req ready is high only when idle, and the result stays on rsp until taken.
// All multiplies and divides run through one bit-serial unit. Operand
// reduction divides curve a and the coordinates of P and Q by the modulus in
// turn. One point addition finds the slope inverse by extended Euclid steps,
// each a divide and a multiply, then multiplies by the inverse, squares lambda
// and multiplies lambda by (x - x'); doubling adds two more multiplies. A
// scalar multiply repeats the addition scalar - 1 times. A modulus below two
// answers infinity at once.

module ec_point_add_and_multiply #(
   parameter int COORD_WIDTH  = ecpa_pkg::DEF_COORD_WIDTH,
   parameter int SCALAR_WIDTH = ecpa_pkg::DEF_SCALAR_WIDTH
) (
   input  wire        clock,
   input  wire        reset,
   ecpa_req_if.sink   req_chan,
   ecpa_rsp_if.source rsp_chan,
   ecpa_csr_if.sink   csr_chan
);
   import ecpa_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int SW = SCALAR_WIDTH;

   // sequencer states, one-hot
   typedef enum logic [15:0] {
      S_IDLE  = 16'b0000_0000_0000_0001,
      S_RED   = 16'b0000_0000_0000_0010,  // issue one operand reduction
      S_REDW  = 16'b0000_0000_0000_0100,  // wait reduction remainder
      S_SETUP = 16'b0000_0000_0000_1000,
      S_CHECK = 16'b0000_0000_0001_0000,  // count remaining additions
      S_ADD   = 16'b0000_0000_0010_0000,  // classify the addition
      S_DBL1  = 16'b0000_0000_0100_0000,  // wait x*x
      S_DBL2  = 16'b0000_0000_1000_0000,  // wait 3*x^2
      S_EUC   = 16'b0000_0001_0000_0000,  // euclid step head
      S_EDIV  = 16'b0000_0010_0000_0000,  // wait r0 / r1
      S_EMUL  = 16'b0000_0100_0000_0000,  // wait q * y1
      S_LAM   = 16'b0000_1000_0000_0000,  // wait num * inverse
      S_LAM2  = 16'b0001_0000_0000_0000,  // wait lambda^2
      S_YMUL  = 16'b0010_0000_0000_0000,  // wait lambda * (x - x')
      S_DONE  = 16'b0100_0000_0000_0000,  // result on rsp
      S_SPARE = 16'b1000_0000_0000_0000   // unused, falls back to idle
   } state_type;

   function automatic logic [CW-1:0] add_mod(input logic [CW-1:0] x,
                                             input logic [CW-1:0] y,
                                             input logic [CW-1:0] mm);
      logic [CW:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, mm}) s = s - {1'b0, mm};
      return s[CW-1:0];
   endfunction

   function automatic logic [CW-1:0] sub_mod(input logic [CW-1:0] x,
                                             input logic [CW-1:0] y,
                                             input logic [CW-1:0] mm);
      logic [CW-1:0] d;
      d = x - y;
      if (x < y) d = d + mm;
      return d;
   endfunction

   // configuration registers
   logic [CW-1:0] modulus_ff, curve_a_ff;

   state_type     state_ff, state_in;
   red_sel_type   red_ff, red_in;
   logic          cmd_ff, cmd_in;
   logic [SW-1:0] scalar_ff, scalar_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   // running point R and addend Q
   logic [CW-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic          rinf_ff, rinf_in;
   logic [CW-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic          qinf_ff, qinf_in;
   logic [CW-1:0] a_red_ff, a_red_in;
   // slope and euclid registers
   logic [CW-1:0] num_ff, num_in;
   logic [CW-1:0] r0_ff, r0_in, r1_ff, r1_in, rem_ff, rem_in;
   logic [CW-1:0] y0_ff, y0_in, y1_ff, y1_in;
   logic [CW-1:0] lam_ff, lam_in, nx_ff, nx_in;

   // shared unit
   alu_cmd_type   alu_cmd;
   alu_stat_type  alu_stat;
   logic [CW-1:0] alu_a, alu_b, alu_m, alu_res, alu_quo;

   logic [CW-1:0] red_val, qm, nx_val;
   logic          req_fire, rsp_fire;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   ecpa_alu #(
      .COORD_WIDTH(CW)
   ) u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .a     (alu_a),
      .b     (alu_b),
      .m     (alu_m),
      .stat  (alu_stat),
      .res   (alu_res),
      .quo   (alu_quo)
   );

   // register writes are always taken
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= CW'(MODULUS_RESET);
         curve_a_ff <= CW'(CURVE_A_RESET);
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            CSR_MODULUS: modulus_ff <= csr_chan.data;
            CSR_CURVE_A: curve_a_ff <= csr_chan.data;
            default:     modulus_ff <= modulus_ff;
         endcase
      end
   end

   // operand picked for the current reduction
   always_comb begin
      unique case (red_ff)
         RED_CURVE_A: red_val = a_red_ff;
         RED_P_X:     red_val = rx_ff;
         RED_P_Y:     red_val = ry_ff;
         RED_Q_X:     red_val = qx_ff;
         RED_Q_Y:     red_val = qy_ff;
         default:     red_val = '0;
      endcase
   end

   // euclid quotient is at most the modulus
   assign qm     = (alu_quo >= modulus_ff) ? alu_quo - modulus_ff : alu_quo;
   // new x = lambda^2 - x_r - x_q
   assign nx_val = sub_mod(sub_mod(alu_res, rx_ff, modulus_ff), qx_ff, modulus_ff);

   always_comb begin
      state_in  = state_ff;
      red_in    = red_ff;
      cmd_in    = cmd_ff;
      scalar_in = scalar_ff;
      cnt_in    = cnt_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      rinf_in   = rinf_ff;
      qx_in     = qx_ff;
      qy_in     = qy_ff;
      qinf_in   = qinf_ff;
      a_red_in  = a_red_ff;
      num_in    = num_ff;
      r0_in     = r0_ff;
      r1_in     = r1_ff;
      rem_in    = rem_ff;
      y0_in     = y0_ff;
      y1_in     = y1_ff;
      lam_in    = lam_ff;
      nx_in     = nx_ff;
      alu_cmd   = '{start: 1'b0, op: ALU_MULMOD};
      alu_a     = '0;
      alu_b     = '0;
      alu_m     = modulus_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_chan.command;
               scalar_in = req_chan.scalar;
               rx_in     = req_chan.p_x;
               ry_in     = req_chan.p_y;
               rinf_in   = req_chan.p_at_infinity;
               qx_in     = req_chan.q_x;
               qy_in     = req_chan.q_y;
               qinf_in   = req_chan.q_at_infinity;
               a_red_in  = curve_a_ff;
               red_in    = RED_CURVE_A;
               if (modulus_ff < CW'(2)) begin
                  // degenerate modulus answers infinity
                  rinf_in  = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_RED;
               end
            end
         end
         S_RED: begin
            if (red_ff == RED_FINISHED) begin
               state_in = S_SETUP;
            end else begin
               alu_cmd  = '{start: 1'b1, op: ALU_DIVIDE};
               alu_a    = red_val;
               state_in = S_REDW;
            end
         end
         S_REDW: begin
            if (alu_stat.done) begin
               unique case (red_ff)
                  RED_CURVE_A: begin
                     a_red_in = alu_res;
                     red_in   = RED_P_X;
                  end
                  RED_P_X: begin
                     rx_in  = alu_res;
                     red_in = RED_P_Y;
                  end
                  RED_P_Y: begin
                     ry_in  = alu_res;
                     red_in = RED_Q_X;
                  end
                  RED_Q_X: begin
                     qx_in  = alu_res;
                     red_in = RED_Q_Y;
                  end
                  RED_Q_Y: begin
                     qy_in  = alu_res;
                     red_in = RED_FINISHED;
                  end
                  default: red_in = RED_FINISHED;
               endcase
               state_in = S_RED;
            end
         end
         S_SETUP: begin
            if (cmd_ff == CMD_ADD) begin
               cnt_in   = SW'(1);
               state_in = S_CHECK;
            end else if (scalar_ff == '0) begin
               rinf_in  = 1'b1;
               state_in = S_DONE;
            end else begin
               // R = P, Q = P, then scalar - 1 additions
               qx_in    = rx_ff;
               qy_in    = ry_ff;
               qinf_in  = rinf_ff;
               cnt_in   = scalar_ff - 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            if (rinf_ff) begin
               rx_in    = qx_ff;
               ry_in    = qy_ff;
               rinf_in  = qinf_ff;
               state_in = S_CHECK;
            end else if (qinf_ff) begin
               state_in = S_CHECK;
            end else if (rx_ff == qx_ff) begin
               if (add_mod(ry_ff, qy_ff, modulus_ff) == '0) begin
                  // opposite points
                  rinf_in  = 1'b1;
                  state_in = S_CHECK;
               end else begin
                  alu_cmd  = '{start: 1'b1, op: ALU_MULMOD};
                  alu_a    = rx_ff;
                  alu_b    = rx_ff;
                  state_in = S_DBL1;
               end
            end else begin
               // chord slope (qy - ry) / (qx - rx)
               num_in   = sub_mod(qy_ff, ry_ff, modulus_ff);
               r0_in    = modulus_ff;
               r1_in    = sub_mod(qx_ff, rx_ff, modulus_ff);
               y0_in    = '0;
               y1_in    = CW'(1);
               state_in = S_EUC;
            end
         end
         S_DBL1: begin
            if (alu_stat.done) begin
               alu_cmd  = '{start: 1'b1, op: ALU_MULMOD};
               alu_a    = alu_res;
               alu_b    = CW'(TRIPLE);
               state_in = S_DBL2;
            end
         end
         S_DBL2: begin
            if (alu_stat.done) begin
               // tangent slope (3x^2 + a) / 2y
               num_in   = add_mod(alu_res, a_red_ff, modulus_ff);
               r0_in    = modulus_ff;
               r1_in    = add_mod(ry_ff, ry_ff, modulus_ff);
               y0_in    = '0;
               y1_in    = CW'(1);
               state_in = S_EUC;
            end
         end
         S_EUC: begin
            if (r1_ff == '0) begin
               // inverse is y0 (zero denominator gives zero)
               alu_cmd  = '{start: 1'b1, op: ALU_MULMOD};
               alu_a    = num_ff;
               alu_b    = y0_ff;
               state_in = S_LAM;
            end else begin
               // r0 / r1, divisor goes on the unit's modulus input
               alu_cmd  = '{start: 1'b1, op: ALU_DIVIDE};
               alu_a    = r0_ff;
               alu_b    = '0;
               alu_m    = r1_ff;
               state_in = S_EDIV;
            end
         end
         S_EDIV: begin
            if (alu_stat.done) begin
               rem_in   = alu_res;
               alu_cmd  = '{start: 1'b1, op: ALU_MULMOD};
               alu_a    = qm;
               alu_b    = y1_ff;
               state_in = S_EMUL;
            end
         end
         S_EMUL: begin
            if (alu_stat.done) begin
               r0_in    = r1_ff;
               r1_in    = rem_ff;
               y0_in    = y1_ff;
               y1_in    = sub_mod(y0_ff, alu_res, modulus_ff);
               state_in = S_EUC;
            end
         end
         S_LAM: begin
            if (alu_stat.done) begin
               lam_in   = alu_res;
               alu_cmd  = '{start: 1'b1, op: ALU_MULMOD};
               alu_a    = alu_res;
               alu_b    = alu_res;
               state_in = S_LAM2;
            end
         end
         S_LAM2: begin
            if (alu_stat.done) begin
               nx_in    = nx_val;
               alu_cmd  = '{start: 1'b1, op: ALU_MULMOD};
               alu_a    = lam_ff;
               alu_b    = sub_mod(rx_ff, nx_val, modulus_ff);
               state_in = S_YMUL;
            end
         end
         S_YMUL: begin
            if (alu_stat.done) begin
               rx_in    = nx_ff;
               ry_in    = sub_mod(alu_res, ry_ff, modulus_ff);
               rinf_in  = 1'b0;
               state_in = S_CHECK;
            end
         end
         S_DONE: begin
            if (rsp_fire) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         red_ff   <= RED_CURVE_A;
      end else begin
         state_ff <= state_in;
         red_ff   <= red_in;
      end
      cmd_ff    <= cmd_in;
      scalar_ff <= scalar_in;
      cnt_ff    <= cnt_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      rinf_ff   <= rinf_in;
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      qinf_ff   <= qinf_in;
      a_red_ff  <= a_red_in;
      num_ff    <= num_in;
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      rem_ff    <= rem_in;
      y0_ff     <= y0_in;
      y1_ff     <= y1_in;
      lam_ff    <= lam_in;
      nx_ff     <= nx_in;
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = (state_ff == S_DONE);
   assign rsp_chan.r_x           = rinf_ff ? '0 : rx_ff;
   assign rsp_chan.r_y           = rinf_ff ? '0 : ry_ff;
   assign rsp_chan.r_at_infinity = rinf_ff;

   // the shared unit is never restarted mid-operation
   a_alu_no_restart: assert property (@(posedge clock) disable iff (reset)
      alu_cmd.start |-> !alu_stat.busy)
      else $error("alu started while busy");

   // unit finishes only while the sequencer waits for it
   a_alu_done_waited: assert property (@(posedge clock) disable iff (reset)
      alu_stat.done |-> (state_ff == S_REDW || state_ff == S_DBL1 ||
                         state_ff == S_DBL2 || state_ff == S_EDIV ||
                         state_ff == S_EMUL || state_ff == S_LAM ||
                         state_ff == S_LAM2 || state_ff == S_YMUL))
      else $error("alu result not expected");

   // no new transaction while a result is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request accepted with result pending");

endmodule

`default_nettype wire

// File: sim/tb.sv
// testbench for ec_point_add_and_multiply: random and directed point transactions
// depends on ecpa_pkg, the channel interfaces in ecpa_if.sv and the block itself
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ecpa_pkg::*;

   localparam int CW           = DEF_COORD_WIDTH;
   localparam int SW           = DEF_SCALAR_WIDTH;
   localparam int WATCHDOG_MAX = 400000;
   localparam int DRAIN_CYCLES = 3000;

   typedef struct {
      logic          command;
      logic [CW-1:0] p_x;
      logic [CW-1:0] p_y;
      logic          p_at_infinity;
      logic [CW-1:0] q_x;
      logic [CW-1:0] q_y;
      logic          q_at_infinity;
      logic [SW-1:0] scalar;
   } point_op_t;

   typedef struct {
      logic [CW-1:0] r_x;
      logic [CW-1:0] r_y;
      logic          r_at_infinity;
   } point_res_t;

   // predictor's view of a point, wide enough for products mod p
   typedef struct {
      longint unsigned x;
      longint unsigned y;
      bit              inf;
   } affine_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ecpa_req_if #(.COORD_WIDTH(CW), .SCALAR_WIDTH(SW)) req_bus ();
   ecpa_rsp_if #(.COORD_WIDTH(CW)) rsp_bus ();
   ecpa_csr_if #(.INDEX_WIDTH(CSR_INDEX_WIDTH), .DATA_WIDTH(CW)) csr_bus ();

   ec_point_add_and_multiply #(.COORD_WIDTH(CW), .SCALAR_WIDTH(SW)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #4 clock = ~clock;

   // testbench copy of the field registers
   longint unsigned field_mod = MODULUS_RESET;
   longint unsigned field_a   = CURVE_A_RESET;

   point_op_t  pending_ops[$];
   point_res_t expected_points[$];
   point_op_t  shown_op;
   int         accepted_ops = 0;
   int         error_count  = 0;
   int         idle_cycles  = 0;

   // extended euclid, bezout coefficient tracked mod m; inverse of zero is zero
   function automatic longint unsigned euclid_inverse(longint unsigned v, longint unsigned m);
      longint unsigned r0, r1, r2, y0, y1, y2, qt;
      r0 = m;
      r1 = v % m;
      y0 = 0;
      y1 = 1;
      while (r1 != 0) begin
         qt = r0 / r1;
         r2 = r0 - qt * r1;
         y2 = (y0 + m - ((qt % m) * y1) % m) % m;
         r0 = r1; r1 = r2;
         y0 = y1; y1 = y2;
      end
      return y0 % m;
   endfunction

   // chord and tangent rule with infinity handling
   function automatic affine_t point_sum(affine_t p, affine_t q, longint unsigned a,
                                         longint unsigned m);
      affine_t         r;
      longint unsigned num, den, lam;
      if (p.inf) return q;
      if (q.inf) return p;
      r.inf = 0;
      if (p.x == q.x) begin
         if ((p.y + q.y) % m == 0) begin
            r.x = 0; r.y = 0; r.inf = 1;
            return r;
         end
         num = (TRIPLE * ((p.x * p.x) % m) + a) % m;
         den = (2 * p.y) % m;
      end else begin
         num = (q.y + m - p.y) % m;
         den = (q.x + m - p.x) % m;
      end
      lam = (num * euclid_inverse(den, m)) % m;
      r.x = ((lam * lam) % m + 2 * m - p.x - q.x) % m;
      r.y = ((lam * ((p.x + m - r.x) % m)) % m + m - p.y) % m;
      return r;
   endfunction

   function automatic point_res_t predict_point(point_op_t op);
      affine_t         p, q, r;
      longint unsigned m, a;
      point_res_t      res;
      m = field_mod;
      r.x = 0; r.y = 0; r.inf = 1;
      if (m >= 2) begin
         a = field_a % m;
         p.x = op.p_x % m; p.y = op.p_y % m; p.inf = op.p_at_infinity;
         q.x = op.q_x % m; q.y = op.q_y % m; q.inf = op.q_at_infinity;
         if (op.command == CMD_ADD)
            r = point_sum(p, q, a, m);
         else if (op.scalar != 0) begin
            r = p;
            for (int i = 2; i <= op.scalar; i++)
               r = point_sum(r, p, a, m);
         end
      end
      if (r.inf) begin
         r.x = 0; r.y = 0;
      end
      res.r_x = r.x[CW-1:0];
      res.r_y = r.y[CW-1:0];
      res.r_at_infinity = r.inf;
      return res;
   endfunction

   // random idling, switched off over one long stretch of transactions
   function automatic bit idle_roll();
      if (accepted_ops >= 400 && accepted_ops < 700) return 0;
      return $urandom_range(0, 99) < 17;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_points.push_back(predict_point(shown_op));
            accepted_ops <= accepted_ops + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_ops.size() > 0 && !idle_roll()) begin
               shown_op = pending_ops.pop_front();
               req_bus.command       <= shown_op.command;
               req_bus.p_x           <= shown_op.p_x;
               req_bus.p_y           <= shown_op.p_y;
               req_bus.p_at_infinity <= shown_op.p_at_infinity;
               req_bus.q_x           <= shown_op.q_x;
               req_bus.q_y           <= shown_op.q_y;
               req_bus.q_at_infinity <= shown_op.q_at_infinity;
               req_bus.scalar        <= shown_op.scalar;
               req_bus.valid         <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      point_res_t want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_points.size() == 0) begin
               $error("result transaction with nothing expected");
               error_count++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_bus.r_x !== want.r_x) begin
                  $error("r_x expected %0d actual %0d", want.r_x, rsp_bus.r_x);
                  error_count++;
               end
               if (rsp_bus.r_y !== want.r_y) begin
                  $error("r_y expected %0d actual %0d", want.r_y, rsp_bus.r_y);
                  error_count++;
               end
               if (rsp_bus.r_at_infinity !== want.r_at_infinity) begin
                  $error("r_at_infinity expected %0d actual %0d",
                         want.r_at_infinity, rsp_bus.r_at_infinity);
                  error_count++;
               end
            end
         end
         rsp_bus.ready <= !idle_roll();
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CW-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_MODULUS) field_mod = 64'(value);
      else field_a = 64'(value);
   endtask

   // waits for the queue and the block to drain
   task automatic drain();
      while (pending_ops.size() > 0 || req_bus.valid || expected_points.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [CW-1:0] rand_coord();
      if (field_mod >= 2 && $urandom_range(0, 9) != 0)
         return CW'($urandom_range(0, int'(field_mod) - 1));
      return CW'($urandom);
   endfunction

   function automatic point_op_t make_op(logic cmd, logic [CW-1:0] px, logic [CW-1:0] py,
                                         logic pinf, logic [CW-1:0] qx, logic [CW-1:0] qy,
                                         logic qinf, logic [SW-1:0] k);
      point_op_t op;
      op.command = cmd; op.p_x = px; op.p_y = py; op.p_at_infinity = pinf;
      op.q_x = qx; op.q_y = qy; op.q_at_infinity = qinf; op.scalar = k;
      return op;
   endfunction

   // random transaction; full-range scalars only where the block answers at once
   function automatic point_op_t random_op();
      point_op_t op;
      int        shape;
      op.command = 1'($urandom_range(0, 1));
      op.p_x = rand_coord();
      op.p_y = rand_coord();
      op.q_x = rand_coord();
      op.q_y = rand_coord();
      op.p_at_infinity = ($urandom_range(0, 9) == 0);
      op.q_at_infinity = ($urandom_range(0, 9) == 0);
      shape = $urandom_range(0, 9);
      if (shape < 2) begin
         // same point, tangent rule
         op.q_x = op.p_x; op.q_y = op.p_y;
      end else if (shape == 2 && field_mod >= 2) begin
         // negated point
         op.q_x = op.p_x;
         op.q_y = CW'((field_mod - op.p_y % field_mod) % field_mod);
      end else if (shape == 3) begin
         // same x, unrelated y
         op.q_x = op.p_x;
      end
      if (field_mod < 2) op.scalar = SW'($urandom);
      else op.scalar = SW'($urandom_range(0, 3));
      return op;
   endfunction

   task automatic run_phase(logic [CW-1:0] m, logic [CW-1:0] a, int count);
      write_reg(CSR_MODULUS, m);
      write_reg(CSR_CURVE_A, a);
      repeat (count) pending_ops.push_back(random_op());
      drain();
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.command = CMD_ADD;
      req_bus.p_x = '0; req_bus.p_y = '0; req_bus.p_at_infinity = 1'b0;
      req_bus.q_x = '0; req_bus.q_y = '0; req_bus.q_at_infinity = 1'b0;
      req_bus.scalar = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_MODULUS;
      csr_bus.data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part on the reset field, p = 97, a = 2
      pending_ops.push_back(make_op(CMD_ADD, 3, 10, 1, 5, 7, 0, 0));    // p at infinity
      pending_ops.push_back(make_op(CMD_ADD, 3, 10, 0, 5, 7, 1, 0));    // q at infinity
      pending_ops.push_back(make_op(CMD_ADD, 3, 10, 1, 5, 7, 1, 0));    // both at infinity
      pending_ops.push_back(make_op(CMD_ADD, 3, 10, 0, 3, 87, 0, 0));   // y values cancel
      pending_ops.push_back(make_op(CMD_ADD, 3, 10, 0, 3, 10, 0, 0));   // doubling
      pending_ops.push_back(make_op(CMD_ADD, 3, 10, 0, 3, 20, 0, 0));   // same x, other y
      pending_ops.push_back(make_op(CMD_ADD, 5, 0, 0, 5, 0, 0, 0));     // y of zero doubled
      pending_ops.push_back(make_op(CMD_ADD, 3, 10, 0, 40, 61, 0, 0));  // chord
      pending_ops.push_back(make_op(CMD_ADD, 5, 10, 0, 102, 107, 0, 0));// unreduced, equal
      pending_ops.push_back(make_op(CMD_ADD, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 16'hFFFF));
      pending_ops.push_back(make_op(CMD_ADD, 0, 0, 0, 16'hFFFF, 16'hFFFE, 0, 0));
      pending_ops.push_back(make_op(CMD_MUL, 3, 10, 0, 0, 0, 0, 0));    // scalar zero
      pending_ops.push_back(make_op(CMD_MUL, 3, 10, 0, 0, 0, 0, 1));
      pending_ops.push_back(make_op(CMD_MUL, 3, 10, 0, 16'hFFFF, 16'hFFFF, 1, 2));
      pending_ops.push_back(make_op(CMD_MUL, 3, 10, 0, 0, 0, 0, 5));
      pending_ops.push_back(make_op(CMD_MUL, 3, 10, 1, 0, 0, 0, 3));    // infinity times k
      pending_ops.push_back(make_op(CMD_MUL, 16'hFFFF, 0, 0, 0, 0, 0, 2));
      repeat (330) pending_ops.push_back(random_op());
      drain();

      run_phase(16'd65521, 16'd65534, 250);   // largest prime, unreduced a
      run_phase(16'd3, 16'd0, 200);           // smallest odd prime
      run_phase(16'd0, 16'd7, 60);            // degenerate modulus, any scalar
      run_phase(16'd1, 16'd65535, 40);
      run_phase(16'd65535, 16'd12345, 250);   // composite modulus
      run_phase(16'd251, 16'd250, 250);
      run_phase(16'd2, 16'd1, 100);

      while (expected_points.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
